[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a clock, active also during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion sampled on a clock and disabled while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hw/rtl/tsqb_pkg.sv]
// Shared constants and types of the threshold select quintic blend pipeline.
`default_nettype none

package tsqb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int EXT_W = DATA_W + 2;
    localparam int DEN_W = DATA_W + 1;
    localparam int T_W = FRAC_BITS + 1;
    localparam int P_W = FRAC_BITS + 4;
    localparam int PROD_W = T_W + 1 + DEN_W;
    localparam int DIV_STAGES = T_W;

    localparam int POLY_A = 6;
    localparam int POLY_B = 15;
    localparam int POLY_C = 10;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [DEN_W-1:0] t_diff;
    typedef logic [T_W-1:0] t_frac;

    localparam t_frac ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam t_sample SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_sample SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        t_sample low;
        t_diff   diff;
    } t_src;

endpackage

`default_nettype wire

[hw/rtl/tsqb_front.sv]
// Input stage: band classification and divider operand setup.
`default_nettype none

module tsqb_front import tsqb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_sample          i_control_value,
    input  wire t_sample          i_low_value,
    input  wire t_sample          i_high_value,
    input  wire t_sample          i_threshold_value,
    input  wire t_sample          i_falloff_value,
    output logic                  o_valid,
    output logic [DEN_W-1:0]      o_num,
    output logic [DEN_W-1:0]      o_den,
    output t_src                  o_src
);

    logic signed [EXT_W-1:0] band_pos;
    logic [DEN_W-1:0] den_band;
    logic [DEN_W-1:0] n_num;
    logic [DEN_W-1:0] n_den;
    t_src n_src;

    logic r_valid;
    logic [DEN_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    t_src r_src;

    always_comb begin
        band_pos = EXT_W'(i_control_value) - EXT_W'(i_threshold_value)
                 + EXT_W'(i_falloff_value);
        den_band = {i_falloff_value, 1'b0};
        n_src.low = i_low_value;
        n_src.diff = DEN_W'(i_high_value) - DEN_W'(i_low_value);
        if (i_falloff_value > 32'sd0) begin
            n_den = den_band;
            if (band_pos < 0) begin
                n_num = '0;
            end else if (band_pos > $signed({1'b0, den_band})) begin
                n_num = den_band;
            end else begin
                n_num = band_pos[DEN_W-1:0];
            end
        end else begin
            n_den = DEN_W'(1);
            n_num = (i_control_value < i_threshold_value) ? '0 : DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num;
            r_den <= n_den;
            r_src <= n_src;
        end
    end

    assign o_valid = r_valid;
    assign o_num = r_num;
    assign o_den = r_den;
    assign o_src = r_src;

endmodule

`default_nettype wire

[hw/rtl/tsqb_div.sv]
// Pipelined restoring divider that produces the band position one bit per stage.
`default_nettype none

module tsqb_div import tsqb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [DEN_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire t_src             i_src,
    output logic                  o_valid,
    output t_frac                 o_t,
    output t_src                  o_src
);

    logic             r_valid [DIV_STAGES];
    logic [DEN_W-1:0] r_rem   [DIV_STAGES];
    logic [DEN_W-1:0] r_den   [DIV_STAGES];
    t_frac            r_quo   [DIV_STAGES];
    t_src             r_src   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W-1:0] den_in;
        t_frac quo_in;
        t_src src_in;
        logic valid_in;
        logic fits;
        logic [DEN_W-1:0] n_rem;
        t_frac n_quo;

        if (k == 0) begin : g_first
            assign trial = {1'b0, i_num};
            assign den_in = i_den;
            assign quo_in = '0;
            assign src_in = i_src;
            assign valid_in = i_valid;
        end else begin : g_next
            assign trial = {r_rem[k-1], 1'b0};
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign src_in = r_src[k-1];
            assign valid_in = r_valid[k-1];
        end

        assign fits = trial >= {1'b0, den_in};
        assign n_rem = fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        assign n_quo = {quo_in[T_W-2:0], fits};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= den_in;
                r_quo[k] <= n_quo;
                r_src[k] <= src_in;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_t = r_quo[DIV_STAGES-1];
    assign o_src = r_src[DIV_STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/tsqb_quintic.sv]
// Three-stage quintic smoothstep evaluation of the band position.
`default_nettype none

module tsqb_quintic import tsqb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_frac i_t,
    input  wire t_src  i_src,
    output logic       o_valid,
    output t_frac      o_s,
    output t_src       o_src
);

    logic [2*T_W-1:0] square;
    logic [2*T_W-1:0] cube;
    logic [P_W:0] poly_pos;
    logic [P_W:0] poly_neg;
    logic [T_W+P_W-1:0] blend_prod;
    logic [T_W+P_W-FRAC_BITS-1:0] blend_shift;
    t_frac n_t2;
    t_frac n_t3;
    logic [P_W-1:0] n_p;
    t_frac n_s;

    logic r_valid1;
    logic r_valid2;
    logic r_valid3;
    t_frac r_t1;
    t_frac r_t2;
    t_frac r_t3;
    logic [P_W-1:0] r_p;
    t_frac r_s;
    t_src r_src1;
    t_src r_src2;
    t_src r_src3;

    always_comb begin
        square = (2*T_W)'(i_t) * (2*T_W)'(i_t);
        n_t2 = square[FRAC_BITS +: T_W];

        cube = (2*T_W)'(r_t2) * (2*T_W)'(r_t1);
        n_t3 = cube[FRAC_BITS +: T_W];
        poly_pos = (P_W+1)'(r_t2) * (P_W+1)'(POLY_A) + (P_W+1)'(ONE) * (P_W+1)'(POLY_C);
        poly_neg = (P_W+1)'(r_t1) * (P_W+1)'(POLY_B);
        n_p = (poly_pos > poly_neg) ? P_W'(poly_pos - poly_neg) : '0;

        blend_prod = (T_W+P_W)'(r_t3) * (T_W+P_W)'(r_p);
        blend_shift = blend_prod[T_W+P_W-1:FRAC_BITS];
        n_s = (blend_shift > (T_W+P_W-FRAC_BITS)'(ONE)) ? ONE : blend_shift[T_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_t2 <= n_t2;
            r_src1 <= i_src;
            r_t3 <= n_t3;
            r_p <= n_p;
            r_src2 <= r_src1;
            r_s <= n_s;
            r_src3 <= r_src2;
        end
    end

    assign o_valid = r_valid3;
    assign o_s = r_s;
    assign o_src = r_src3;

endmodule

`default_nettype wire

[hw/rtl/tsqb_blend.sv]
// Blend multiply, floor, saturation and the two-entry output buffer.
`default_nettype none

module tsqb_blend import tsqb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_frac i_s,
    input  wire t_src  i_src,
    input  wire logic  i_stall,
    output logic       o_en,
    output logic       o_valid,
    output t_sample    o_result_value
);

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] scaled;
    logic signed [EXT_W-1:0] sum;
    t_sample n_result;
    logic push;
    logic pop;
    logic [1:0] n_count;

    logic r_valid;
    logic signed [PROD_W-1:0] r_prod;
    t_sample r_low;
    t_sample r_buf [2];
    logic r_wr_ptr;
    logic r_rd_ptr;
    logic [1:0] r_count;

    always_comb begin
        n_prod = $signed({1'b0, i_s}) * i_src.diff;
        scaled = r_prod >>> FRAC_BITS;
        sum = EXT_W'(r_low) + scaled[EXT_W-1:0];
        if (sum > EXT_W'(SAT_MAX)) begin
            n_result = SAT_MAX;
        end else if (sum < EXT_W'(SAT_MIN)) begin
            n_result = SAT_MIN;
        end else begin
            n_result = sum[DATA_W-1:0];
        end
    end

    assign o_en = (r_count != 2'd2);
    assign push = o_en && r_valid;
    assign pop = o_valid && !i_stall;
    assign n_count = r_count + 2'(push) - 2'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_en) begin
                r_valid <= i_valid;
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_prod <= n_prod;
            r_low <= i_src.low;
        end
        if (push) begin
            r_buf[r_wr_ptr] <= n_result;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_result_value = r_buf[r_rd_ptr];

endmodule

`default_nettype wire

[hw/rtl/threshold_select_quintic_blend.sv]
// Top level of the threshold select with quintic smoothstep blend pipeline.
//
// The input channel takes a control, low, high, threshold and falloff sample
// per transaction, all signed fixed point with FRAC_BITS fraction bits. The
// output channel returns one saturated result per input transaction, in order.
// A transaction is taken at a clock edge where valid is high and stall is low.
// From acceptance to output valid a transaction passes through one setup
// stage, one divider stage per quotient bit, three smoothstep stages, one
// blend multiply stage and the output buffer. Throughput is one transaction
// per cycle while the output buffer is not full; every stage advances together.
// A two-entry output buffer holds results while the receiver stalls, so the
// input keeps accepting until the buffer fills; o_in_stall comes from that
// buffer only and never depends on i_out_stall in the same cycle.
// Synchronous active-low reset clears all valid bits and empties the buffer.
`default_nettype none

module threshold_select_quintic_blend import tsqb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_sample i_control_value,
    input  wire t_sample i_low_value,
    input  wire t_sample i_high_value,
    input  wire t_sample i_threshold_value,
    input  wire t_sample i_falloff_value,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_sample      o_result_value
);

    logic en;
    logic front_valid;
    logic [DEN_W-1:0] front_num;
    logic [DEN_W-1:0] front_den;
    t_src front_src;
    logic div_valid;
    t_frac div_t;
    t_src div_src;
    logic quin_valid;
    t_frac quin_s;
    t_src quin_src;

    assign o_in_stall = !en;

    tsqb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_in_valid),
        .i_control_value   (i_control_value),
        .i_low_value       (i_low_value),
        .i_high_value      (i_high_value),
        .i_threshold_value (i_threshold_value),
        .i_falloff_value   (i_falloff_value),
        .o_valid           (front_valid),
        .o_num             (front_num),
        .o_den             (front_den),
        .o_src             (front_src)
    );

    tsqb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_num   (front_num),
        .i_den   (front_den),
        .i_src   (front_src),
        .o_valid (div_valid),
        .o_t     (div_t),
        .o_src   (div_src)
    );

    tsqb_quintic u_quintic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_t     (div_t),
        .i_src   (div_src),
        .o_valid (quin_valid),
        .o_s     (quin_s),
        .o_src   (quin_src)
    );

    tsqb_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (quin_valid),
        .i_s            (quin_s),
        .i_src          (quin_src),
        .i_stall        (i_out_stall),
        .o_en           (en),
        .o_valid        (o_out_valid),
        .o_result_value (o_result_value)
    );

endmodule

`default_nettype wire

[hw/rtl/tsqb_checker.sv]
// Port-level checker for the blend pipeline and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module tsqb_checker import tsqb_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    o_in_stall,
    input wire logic    o_out_valid,
    input wire logic    i_out_stall,
    input wire t_sample o_result_value
);

    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value), "Stalled output transaction changed or dropped.")
    `ASSERT_CLK(a_reset_clear, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "Reset did not empty the pipeline.")
    `ASSERT_CLK_RST(a_stall_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "Input stalled while no result is waiting.")
    `ASSERT_CLK_RST(a_empty_room, i_clk, i_rst_n, !o_out_valid |=> !o_in_stall, "Input stalled one cycle after an empty output.")

endmodule

bind threshold_select_quintic_blend tsqb_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value)
);

`default_nettype wire

[bench/tb_threshold_select_quintic_blend.sv]
// Self-checking testbench for the threshold select quintic blend pipeline.
module tb_threshold_select_quintic_blend;
    import tsqb_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        t_sample control;
        t_sample low;
        t_sample high;
        t_sample thr;
        t_sample fall;
    } t_blend_item;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_sample i_control_value = '0;
    t_sample i_low_value = '0;
    t_sample i_high_value = '0;
    t_sample i_threshold_value = '0;
    t_sample i_falloff_value = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_sample o_result_value;

    t_blend_item item_q[$];
    t_sample     expected_blends[$];
    int          mismatch_count = 0;
    int          in_count = 0;
    int          cycle_count = 0;
    logic        in_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    logic        stall_now;

    threshold_select_quintic_blend dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_control_value  (i_control_value),
        .i_low_value      (i_low_value),
        .i_high_value     (i_high_value),
        .i_threshold_value(i_threshold_value),
        .i_falloff_value  (i_falloff_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_value   (o_result_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sample fit32(longint v);
        if (v > S32_MAX) begin
            v = S32_MAX;
        end else if (v < S32_MIN) begin
            v = S32_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic t_sample blend_result(t_blend_item it);
        longint ctl, lo, hi, thr, fall, lower, upper, t, t2, t3, p, s, sum;
        ctl = it.control;
        lo = it.low;
        hi = it.high;
        thr = it.thr;
        fall = it.fall;
        if (fall > 0) begin
            lower = thr - fall;
            upper = thr + fall;
            if (ctl < lower) begin
                sum = lo;
            end else if (ctl > upper) begin
                sum = hi;
            end else begin
                t = ((ctl - lower) <<< FRAC_BITS) / (2 * fall);
                if (t > UNIT) begin
                    t = UNIT;
                end
                t2 = (t * t) >>> FRAC_BITS;
                t3 = (t2 * t) >>> FRAC_BITS;
                p = POLY_A * t2 - POLY_B * t + POLY_C * UNIT;
                if (p < 0) begin
                    p = 0;
                end
                s = (t3 * p) >>> FRAC_BITS;
                if (s > UNIT) begin
                    s = UNIT;
                end
                sum = lo + ((s * (hi - lo)) >>> FRAC_BITS);
            end
        end else begin
            sum = (ctl < thr) ? lo : hi;
        end
        return fit32(sum);
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0: return SAT_MIN;
            1: return SAT_MAX;
            2: return '0;
            3: return fit32(longint'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_item(t_sample c, t_sample l, t_sample h, t_sample t, t_sample f);
        t_blend_item it;
        it.control = c;
        it.low = l;
        it.high = h;
        it.thr = t;
        it.fall = f;
        item_q.push_back(it);
    endtask

    task automatic add_random_item();
        longint thr, fall, ctl;
        int k;
        thr = rand_sample();
        k = $urandom_range(0, 31);
        fall = 1 + longint'($urandom) % (longint'(1) << k);
        if (fall > S32_MAX) begin
            fall = S32_MAX;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: ctl = thr - fall + longint'($urandom) % (2 * fall + 1);
            6: begin
                case ($urandom_range(0, 3))
                    0: ctl = thr - fall - 1;
                    1: ctl = thr - fall;
                    2: ctl = thr + fall;
                    default: ctl = thr + fall + 1;
                endcase
            end
            7: begin
                fall = ($urandom_range(0, 7) == 0) ? S32_MIN :
                    -longint'($urandom_range(0, 32'h7fff_ffff));
                ctl = thr + longint'($urandom_range(0, 2)) - 1;
            end
            default: begin
                fall = longint'(t_sample'($urandom));
                ctl = longint'(t_sample'($urandom));
            end
        endcase
        add_item(fit32(ctl), rand_sample(), rand_sample(), fit32(thr), fit32(fall));
    endtask

    task automatic report_mismatch(string what, t_sample want, t_sample got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected %0d (0x%08h), got %0d (0x%08h)", what, want, want, got, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            i_in_valid <= 1'b1;
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (item_q.size() != 0) begin
            t_blend_item it;
            it = item_q.pop_front();
            i_control_value <= it.control;
            i_low_value <= it.low;
            i_high_value <= it.high;
            i_threshold_value <= it.thr;
            i_falloff_value <= it.fall;
            i_in_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: stall_now = 1'b0;
            1: stall_now = ($urandom_range(0, 1) != 0);
            2: stall_now = (cycle_count % 3 == 0);
            default: stall_now = ($urandom_range(0, 3) != 0);
        endcase
        i_out_stall <= (hold_left != 0) || stall_now;
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && in_count >= 300 + 350 * holds_done) begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge i_clk) begin
        t_blend_item seen;
        t_sample want;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blends.size() == 0) begin
                report_mismatch("Result transaction with none expected", '0, o_result_value);
            end else begin
                want = expected_blends.pop_front();
                if (o_result_value !== want) begin
                    report_mismatch("result_value mismatch", want, o_result_value);
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen.control = i_control_value;
            seen.low = i_low_value;
            seen.high = i_high_value;
            seen.thr = i_threshold_value;
            seen.fall = i_falloff_value;
            expected_blends.push_back(blend_result(seen));
            in_count <= in_count + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        add_item(-32'sd65536, 32'sd100, 32'sd200, 32'sd0, 32'sd0);
        add_item(32'sd0, 32'sd100, 32'sd200, 32'sd0, 32'sd0);
        add_item(32'sd65536, 32'sd100, 32'sd200, 32'sd0, -32'sd65536);
        add_item(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN);
        add_item(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MIN);
        add_item(-32'sd65536, 32'sd0, 32'sd262144, 32'sd0, 32'sd65536);
        add_item(32'sd65536, 32'sd0, 32'sd262144, 32'sd0, 32'sd65536);
        add_item(-32'sd65537, 32'sd0, 32'sd262144, 32'sd0, 32'sd65536);
        add_item(32'sd65537, 32'sd0, 32'sd262144, 32'sd0, 32'sd65536);
        add_item(32'sd0, 32'sd0, 32'sd262144, 32'sd0, 32'sd65536);
        add_item(32'sd32768, SAT_MIN, SAT_MAX, 32'sd0, 32'sd65536);
        add_item(-32'sd1000, SAT_MAX, SAT_MIN, 32'sd0, 32'sd65536);
        add_item(SAT_MIN, 32'sd5, 32'sd7, SAT_MIN, SAT_MAX);
        add_item(SAT_MAX, 32'sd5, 32'sd7, SAT_MAX, SAT_MAX);
        add_item(SAT_MIN, 32'sd5, 32'sd7, SAT_MAX, SAT_MAX);
        add_item(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX);
        add_item(32'sd0, SAT_MAX, SAT_MAX, 32'sd0, 32'sd1);
        add_item(32'sd1, SAT_MIN, SAT_MIN, 32'sd0, 32'sd1);
        add_item(32'sd12345, -32'sd65536, 32'sd65536, 32'sd0, SAT_MAX);
        add_item(SAT_MAX, 32'sd0, -32'sd1, 32'sd0, 32'sd0);
        add_item(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1);
        add_item(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        repeat (RANDOM_ITEMS) add_random_item();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (item_q.size() != 0 || i_in_valid || expected_blends.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
